FILE: rtl/snappy_pkg.sv
package snappy_pkg;

  typedef enum logic [2:0] {
    PH_HDR   = 3'd0,
    PH_TAG   = 3'd1,
    PH_FIELD = 3'd2,
    PH_LIT   = 3'd3,
    PH_DROP  = 3'd4,
    PH_COPY  = 3'd5,
    PH_CHECK = 3'd6
  } phase_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_BAD_HDR   = 3'd1,
    ST_TRUNC     = 3'd2,
    ST_BAD_OFS   = 3'd3,
    ST_OVERRUN   = 3'd4
  } status_e;

  localparam logic [1:0] TAG_LITERAL = 2'd0;
  localparam logic [1:0] TAG_COPY1   = 2'd1;
  localparam logic [31:0] MAX_LEN_RESET = 32'd65536;

  function automatic logic [2:0] field_total(input logic [7:0] tag);
    logic [2:0] r;
    begin
      r = 3'd4;
      case (tag[1:0])
        TAG_LITERAL: r = 3'(tag[7:2] - 6'd59);
        TAG_COPY1:   r = 3'd1;
        2'd2:        r = 3'd2;
        default:     r = 3'd4;
      endcase
      return r;
    end
  endfunction

endpackage

FILE: rtl/snappy_block_decompressor.sv
// Snappy block decompressor. Compressed bytes enter one word per handshake; the
// block first reads the varint length header, then decodes literal and copy
// tags. A literal data byte is taken in and gives one result word out. A copy
// replays up to 64 bytes from the history RAM, one byte per cycle through the
// single RAM read port while the output is taken (a check state first also
// issues the first read), and input is held off meanwhile. Errors and the final
// status ride on the last result word (out_last_o); a status-only word is sent
// when the ending input word produced no byte. HISTORY_DEPTH sets the copy
// window and must be a power of two.
module snappy_block_decompressor
  import snappy_pkg::*;
#(
  parameter int unsigned HISTORY_DEPTH = 65536
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        max_output_len_we_i,
  input  logic [31:0] max_output_len_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  in_byte_i,
  input  logic        in_last_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  out_byte_o,
  output logic        has_byte_o,
  output logic        out_last_o,
  output logic [2:0]  status_o
);

  localparam int unsigned AW = $clog2(HISTORY_DEPTH);

  logic [31:0] max_len_q;
  phase_e      phase_q, phase_d;
  logic [2:0]  hshift_q, hshift_d;
  logic [31:0] remain_q, remain_d;
  logic [32:0] produced_q, produced_d;
  logic [7:0]  tag_q, tag_d;
  logic [2:0]  due_q, due_d;
  logic [31:0] accum_q, accum_d;
  logic [31:0] lit_q, lit_d;
  logic [AW-1:0] wptr_q, wptr_d;
  logic        last_q, last_d;
  logic [6:0]  clen_q, clen_d;
  logic        rd_pend_q, rd_pend_d;
  logic        done_q, done_d;

  // output register
  logic        ov_q, ov_d;
  logic [7:0]  ob_q, ob_d;
  logic        oh_q, oh_d, ol_q, ol_d;
  logic [2:0]  os_q, os_d;

  logic [7:0]  mem [HISTORY_DEPTH];
  logic [7:0]  rdata_q;
  logic        we;
  logic [7:0]  wdata;
  logic [AW-1:0] raddr;

  logic out_free;
  logic acc;
  assign out_free = !ov_q || out_ready_i;

  always_comb begin
    in_ready_o = 1'b0;
    case (phase_q)
      PH_HDR, PH_TAG, PH_FIELD, PH_LIT: in_ready_o = out_free;
      PH_DROP: in_ready_o = 1'b1;
      default: in_ready_o = 1'b0;
    endcase
  end
  assign acc = in_valid_i && in_ready_o;

  always_comb begin
    logic [31:0] hv;
    logic [32:0] len;
    logic [2:0]  pos;
    logic [31:0] ofs;
    logic        fin;
    logic [2:0]  st;
    logic        emitb;
    logic [7:0]  eb;

    phase_d = phase_q; hshift_d = hshift_q; remain_d = remain_q;
    produced_d = produced_q; tag_d = tag_q; due_d = due_q; accum_d = accum_q;
    lit_d = lit_q; wptr_d = wptr_q; last_d = last_q; clen_d = clen_q;
    rd_pend_d = 1'b0; done_d = done_q;
    ov_d = ov_q && !out_ready_i; ob_d = ob_q; oh_d = oh_q; ol_d = ol_q; os_d = os_q;
    fin = 1'b0; st = ST_OK; emitb = 1'b0; eb = 8'd0;
    we = 1'b0; wdata = 8'd0;
    hv = 32'(in_byte_i[6:0]) << (5'd7 * 5'(hshift_q));
    len = 33'd0; pos = 3'd0;
    ofs = 32'(accum_q);
    raddr = wptr_q - AW'(ofs);

    case (phase_q)
      PH_HDR: if (acc) begin
        last_d = in_last_i;
        if (hshift_q >= 3'd4 && in_byte_i > 8'h0f) begin
          fin = 1'b1; st = ST_BAD_HDR;
        end else begin
          remain_d = remain_q | hv;
          if (in_byte_i[7]) begin
            hshift_d = hshift_q + 3'd1;
            if (in_last_i) begin fin = 1'b1; st = ST_TRUNC; end
          end else if (remain_d == 32'd0 || remain_d > max_len_q) begin
            fin = 1'b1; st = ST_BAD_HDR;
          end else if (in_last_i) begin
            fin = 1'b1; st = ST_TRUNC;
          end else phase_d = PH_TAG;
        end
      end
      PH_TAG: if (acc) begin
        last_d = in_last_i;
        tag_d = in_byte_i;
        if (in_byte_i[1:0] == TAG_LITERAL && in_byte_i[7:2] < 6'd60) begin
          len = 33'(in_byte_i[7:2]) + 33'd1;
          if (in_last_i) begin fin = 1'b1; st = ST_TRUNC; end
          else if (len > 33'(remain_q)) begin fin = 1'b1; st = ST_OVERRUN; end
          else begin lit_d = len[31:0]; phase_d = PH_LIT; end
        end else begin
          due_d = field_total(in_byte_i);
          accum_d = 32'd0;
          if (in_last_i) begin fin = 1'b1; st = ST_TRUNC; end
          else phase_d = PH_FIELD;
        end
      end
      PH_FIELD: if (acc) begin
        last_d = in_last_i;
        pos = 3'((field_total(tag_q) - due_q) & 3'd3);
        accum_d = accum_q | (32'(in_byte_i) << (5'd8 * 5'(pos)));
        due_d = due_q - 3'd1;
        if (due_d != 3'd0) begin
          if (in_last_i) begin fin = 1'b1; st = ST_TRUNC; end
        end else if (tag_q[1:0] == TAG_LITERAL) begin
          len = 33'(accum_d) + 33'd1;
          if (in_last_i) begin fin = 1'b1; st = ST_TRUNC; end
          else if (len > 33'(remain_q)) begin fin = 1'b1; st = ST_OVERRUN; end
          else begin lit_d = len[31:0]; phase_d = PH_LIT; end
        end else begin
          if (tag_q[1:0] == TAG_COPY1) begin
            accum_d = {21'd0, tag_q[7:5], accum_d[7:0]};
            clen_d = 7'(tag_q[4:2]) + 7'd4;
          end else clen_d = 7'(tag_q[7:2]) + 7'd1;
          phase_d = PH_CHECK;
        end
      end
      PH_CHECK: if (out_free) begin
        // check offset then length
        if (ofs == 32'd0 || 33'(ofs) > produced_q || 33'(ofs) > 33'(HISTORY_DEPTH)) begin
          fin = 1'b1; st = ST_BAD_OFS;
        end else if (32'(clen_q) > remain_q) begin
          fin = 1'b1; st = ST_OVERRUN;
        end else begin
          remain_d = remain_q - 32'(clen_q);
          rd_pend_d = 1'b1;
          phase_d = PH_COPY;
        end
      end
      PH_COPY: if (out_free) begin
        // read data is registered; hold ov until taken
        if (rd_pend_q) begin
          emitb = 1'b1; eb = rdata_q;
          clen_d = clen_q - 7'd1;
          if (clen_d == 7'd0) begin
            if (remain_q == 32'd0) begin fin = 1'b1; st = ST_OK; end
            else if (last_q) begin fin = 1'b1; st = ST_TRUNC; end
            else phase_d = PH_TAG;
          end else rd_pend_d = 1'b1;
        end else rd_pend_d = 1'b1;
      end
      PH_LIT: if (acc) begin
        emitb = 1'b1; eb = in_byte_i;
        last_d = in_last_i;
        lit_d = lit_q - 32'd1;
        remain_d = remain_q - 32'd1;
        if (remain_d == 32'd0) begin fin = 1'b1; st = ST_OK; end
        else if (in_last_i) begin fin = 1'b1; st = ST_TRUNC; end
        else if (lit_d == 32'd0) phase_d = PH_TAG;
      end
      default: if (acc && in_last_i) phase_d = PH_HDR;
    endcase

    if (emitb) begin
      we = 1'b1; wdata = eb;
      wptr_d = wptr_q + AW'(1);
      produced_d = produced_q + 33'd1;
      raddr = wptr_d - AW'(ofs);
    end
    if (emitb || fin) begin
      ov_d = 1'b1; ob_d = eb; oh_d = emitb; ol_d = fin; os_d = fin ? st : ST_OK;
    end
    if (fin) begin
      if (last_d) begin
        phase_d = PH_HDR; hshift_d = 3'd0; remain_d = 32'd0; produced_d = 33'd0;
        tag_d = 8'd0; due_d = 3'd0; accum_d = 32'd0; lit_d = 32'd0;
        wptr_d = '0; done_d = 1'b0;
      end else begin
        phase_d = PH_DROP; done_d = 1'b1;
      end
    end
    if (phase_q == PH_DROP && acc && in_last_i) begin
      hshift_d = 3'd0; remain_d = 32'd0; produced_d = 33'd0; tag_d = 8'd0;
      due_d = 3'd0; accum_d = 32'd0; lit_d = 32'd0; wptr_d = '0; done_d = 1'b0;
    end
  end

  // forward the byte written this cycle when the read issued in the same cycle hits it
  always_ff @(posedge clk_i) begin
    if (we) mem[wptr_q] <= wdata;
    rdata_q <= (we && raddr == wptr_q) ? wdata : mem[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= MAX_LEN_RESET;
      phase_q <= PH_HDR; hshift_q <= '0; remain_q <= '0; produced_q <= '0;
      tag_q <= '0; due_q <= '0; accum_q <= '0; lit_q <= '0; wptr_q <= '0;
      last_q <= 1'b0; clen_q <= '0; rd_pend_q <= 1'b0; done_q <= 1'b0;
      ov_q <= 1'b0;
    end else begin
      if (max_output_len_we_i) max_len_q <= max_output_len_i;
      phase_q <= phase_d; hshift_q <= hshift_d; remain_q <= remain_d;
      produced_q <= produced_d; tag_q <= tag_d; due_q <= due_d; accum_q <= accum_d;
      lit_q <= lit_d; wptr_q <= wptr_d; last_q <= last_d; clen_q <= clen_d;
      rd_pend_q <= rd_pend_d; done_q <= done_d; ov_q <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ob_q <= ob_d; oh_q <= oh_d; ol_q <= ol_d; os_q <= os_d;
  end

  assign out_valid_o = ov_q;
  assign out_byte_o  = ob_q;
  assign has_byte_o  = oh_q;
  assign out_last_o  = ol_q;
  assign status_o    = os_q;

  a_status_only_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !has_byte_o |-> out_last_o) else $error("status word not last");
  a_status_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_last_o |-> status_o == ST_OK) else $error("status on non-last");
  a_no_input_in_copy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_COPY || phase_q == PH_CHECK) |-> !in_ready_o)
    else $error("input taken during copy");
  a_drop_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_DROP |-> done_q) else $error("drop without end");

endmodule
